/* design/cslm_pkg.sv */
// Shared types and codes of the critical section lock manager.
package cslm_pkg;

    localparam logic [1:0] CMD_REQUEST = 2'd0;
    localparam logic [1:0] CMD_RELEASE = 2'd1;
    localparam logic [1:0] CMD_FINAL   = 2'd2;

    localparam logic [1:0] KIND_GRANT  = 2'd0;
    localparam logic [1:0] KIND_NOTICE = 2'd1;
    localparam logic [1:0] KIND_RANK   = 2'd2;
    localparam logic [1:0] KIND_ERROR  = 2'd3;

    localparam logic [1:0] ERR_NONE       = 2'd0;
    localparam logic [1:0] ERR_QUEUE_FULL = 2'd1;
    localparam logic [1:0] ERR_EMPTY_REL  = 2'd2;

    typedef struct packed {
        logic [1:0] cmd;
        logic [2:0] section;
        logic [5:0] source_process;
    } req_t;

    typedef struct packed {
        logic [1:0] kind;
        logic [5:0] dest_process;
        logic       has_next;
        logic [5:0] next_process;
        logic       first_entry;
        logic [4:0] pending_count;
        logic [5:0] pending_rank;
        logic [1:0] error_code;
        logic       last;
    } res_t;

    typedef struct packed {
        logic len_we;
        logic list_we;
    } pend_ctl_t;

endpackage

/* design/cslm_pend.sv */
// Pending update store: list lengths with a clearing pass, and the rank lists.
module cslm_pend
    import cslm_pkg::*;
#(
    parameter int SLOTS   = 512,
    parameter int ENTRIES = 8192,
    parameter int CNT_W   = 5
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  pend_ctl_t                  ctl,
    input  logic [$clog2(SLOTS)-1:0]   len_addr,
    input  logic [CNT_W-1:0]           len_wdata,
    output logic [CNT_W-1:0]           len_rdata,
    input  logic [$clog2(ENTRIES)-1:0] list_raddr,
    input  logic [$clog2(ENTRIES)-1:0] list_waddr,
    input  logic [5:0]                 list_wdata,
    output logic [5:0]                 list_rdata,
    output logic                       clearing
);

    localparam int SW = $clog2(SLOTS);

    logic [CNT_W-1:0] len_mem [SLOTS];
    logic [5:0]       list_mem [ENTRIES];
    logic [SW-1:0]    clr_reg;
    logic [SW-1:0]    clr_next;
    logic             clearing_reg;
    logic             clearing_next;

    // The length store is swept to zero once after reset, one slot a cycle.
    always_comb
    begin
        clr_next      = clr_reg;
        clearing_next = clearing_reg;
        if (clearing_reg)
        begin
            clr_next = clr_reg + 1'b1;
            if (clr_reg == SW'(SLOTS - 1))
            begin
                clearing_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_reg      <= '0;
            clearing_reg <= 1'b1;
        end
        else
        begin
            clr_reg      <= clr_next;
            clearing_reg <= clearing_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (clearing_reg)
        begin
            len_mem[clr_reg] <= '0;
        end
        else if (ctl.len_we)
        begin
            len_mem[len_addr] <= len_wdata;
        end
        len_rdata <= len_mem[len_addr];
    end

    always_ff @(posedge clk)
    begin
        if (ctl.list_we)
        begin
            list_mem[list_waddr] <= list_wdata;
        end
        list_rdata <= list_mem[list_raddr];
    end

    assign clearing = clearing_reg;

endmodule

/* design/critical_section_lock_manager_core.sv */
// Top level of the critical section lock manager: sequencer, wait queues and section flags.
//
// Usage: an item (cmd, section, source_process) is taken on the request port at a clock
// edge where start is high and busy is low. busy stays high while the item is worked on.
// Each result beat appears on the result port for exactly one cycle with strobe high; the
// receiver cannot hold results off, so it must take every beat as it comes.
// Work done for each item, up to the last result beat (n = pending ranks):
//   request to an empty queue or final update: a grant and n rank beats;
//   request to a busy queue: no result;
//   release with a waiter: the queue memory read and one read-modify-write of the
//   waiter's list length come first;
//   release without a waiter: the notice beat, then one read and one write of the
//   shared length port per process of the section, with busy high throughout;
//   errors: one beat.
// Items with an unused command or an out of range section or rank are taken and dropped.
// After reset the pending length store is swept to zero, during which busy is high.
// Wait queues are circular buffers, so a release moves only a head pointer.
module critical_section_lock_manager_core
    import cslm_pkg::*;
#(
    parameter int NPROC       = 64,
    parameter int NCRIT       = 8,
    parameter int MAX_UPDATES = 16
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic start,
    output logic busy,
    input  req_t request,
    output logic strobe,
    output res_t result
);

    localparam int PW     = (NPROC > 1) ? $clog2(NPROC) : 1;
    localparam int QL_W   = $clog2(NPROC + 1);
    localparam int SEC_W  = (NCRIT > 1) ? $clog2(NCRIT) : 1;
    localparam int SLOTS  = NCRIT * NPROC;
    localparam int SW     = $clog2(SLOTS);
    localparam int ENTRIES = SLOTS * MAX_UPDATES;
    localparam int LAW    = $clog2(ENTRIES);
    localparam int CNT_W  = $clog2(MAX_UPDATES + 1);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_DEC  = 3'd1;
    localparam logic [2:0] S_NOTE = 3'd2;
    localparam logic [2:0] S_ARD  = 3'd3;
    localparam logic [2:0] S_AWR  = 3'd4;
    localparam logic [2:0] S_DRD  = 3'd5;
    localparam logic [2:0] S_DLEN = 3'd6;
    localparam logic [2:0] S_RANK = 3'd7;

    logic [2:0]       state_reg, state_next;
    logic [1:0]       cmd_reg, cmd_next;
    logic [SEC_W-1:0] sec_reg, sec_next;
    logic [5:0]       src_reg, src_next;
    logic [PW-1:0]    proc_reg, proc_next;
    logic             walk_reg, walk_next;
    logic             first_reg, first_next;
    logic [CNT_W-1:0] n_reg, n_next;
    logic [CNT_W-1:0] i_reg, i_next;
    res_t             res_reg, res_next;
    logic             strobe_reg, strobe_next;

    logic [QL_W-1:0]  qlen_reg [NCRIT];
    logic [PW-1:0]    head_reg [NCRIT];
    logic [NCRIT-1:0] never_reg;
    logic             qlen_we, head_we, never_clr;
    logic [QL_W-1:0]  qlen_wdata;
    logic [PW-1:0]    head_wdata;

    logic [5:0]       qmem [SLOTS];
    logic [5:0]       q_rdata;
    logic             q_we;
    logic [SW-1:0]    q_addr;
    logic [PW-1:0]    q_pos;

    pend_ctl_t        pctl;
    logic [SW-1:0]    slot;
    logic [LAW-1:0]   list_base;
    logic [LAW-1:0]   list_raddr;
    logic [LAW-1:0]   list_waddr;
    logic [CNT_W-1:0] len_wdata;
    logic [CNT_W-1:0] len_rdata;
    logic [5:0]       list_rdata;
    logic             clearing;

    logic [QL_W-1:0]  len;
    logic             in_range;
    logic [CNT_W-1:0] sat_len;

    // Position in a circular queue: head plus an offset of at most NPROC, wrapped once.
    function automatic logic [PW-1:0] wrap_pos(input logic [PW-1:0] h,
                                                input logic [QL_W-1:0] off);
        logic [PW:0] s;
        s = (PW + 1)'(h) + (PW + 1)'(off);
        if (s >= (PW + 1)'(NPROC))
        begin
            s = s - (PW + 1)'(NPROC);
        end
        return s[PW-1:0];
    endfunction

    assign len       = qlen_reg[sec_reg];
    assign slot      = SW'(sec_reg) * SW'(NPROC) + SW'(proc_reg);
    assign list_base = LAW'(slot) * LAW'(MAX_UPDATES);
    assign in_range  = (32'(request.section) < NCRIT) && (32'(request.source_process) < NPROC);
    assign sat_len   = (len_rdata > CNT_W'(MAX_UPDATES)) ? CNT_W'(MAX_UPDATES) : len_rdata;
    assign q_addr    = SW'(sec_reg) * SW'(NPROC) + SW'(q_pos);
    assign busy      = (state_reg != S_IDLE) || clearing;

    always_comb
    begin
        state_next  = state_reg;
        cmd_next    = cmd_reg;
        sec_next    = sec_reg;
        src_next    = src_reg;
        proc_next   = proc_reg;
        walk_next   = walk_reg;
        first_next  = first_reg;
        n_next      = n_reg;
        i_next      = i_reg;
        res_next    = '0;
        strobe_next = 1'b0;
        qlen_we     = 1'b0;
        qlen_wdata  = len;
        head_we     = 1'b0;
        head_wdata  = head_reg[sec_reg];
        never_clr   = 1'b0;
        q_we        = 1'b0;
        q_pos       = wrap_pos(head_reg[sec_reg], len);
        pctl        = '0;
        len_wdata   = '0;
        list_raddr  = list_base;
        list_waddr  = list_base + LAW'(len_rdata);
        unique case (state_reg)
            S_IDLE:
            begin
                if (start && !clearing && in_range &&
                    (request.cmd == CMD_REQUEST || request.cmd == CMD_RELEASE ||
                     request.cmd == CMD_FINAL))
                begin
                    cmd_next   = request.cmd;
                    sec_next   = SEC_W'(request.section);
                    src_next   = request.source_process;
                    state_next = S_DEC;
                end
            end
            S_DEC:
            begin
                state_next = S_IDLE;
                priority if (cmd_reg == CMD_REQUEST)
                begin
                    if (len == QL_W'(NPROC))
                    begin
                        strobe_next           = 1'b1;
                        res_next.kind         = KIND_ERROR;
                        res_next.dest_process = src_reg;
                        res_next.error_code   = ERR_QUEUE_FULL;
                        res_next.last         = 1'b1;
                    end
                    else
                    begin
                        q_we       = 1'b1;
                        qlen_we    = 1'b1;
                        qlen_wdata = len + 1'b1;
                        if (len == '0)
                        begin
                            first_next = never_reg[sec_reg];
                            never_clr  = 1'b1;
                            proc_next  = PW'(src_reg);
                            state_next = S_DRD;
                        end
                    end
                end
                else if (cmd_reg == CMD_RELEASE)
                begin
                    if (len == '0)
                    begin
                        strobe_next           = 1'b1;
                        res_next.kind         = KIND_ERROR;
                        res_next.dest_process = src_reg;
                        res_next.error_code   = ERR_EMPTY_REL;
                        res_next.last         = 1'b1;
                    end
                    else if (len > QL_W'(1))
                    begin
                        // Fetch the next waiter, one place behind the head.
                        q_pos      = wrap_pos(head_reg[sec_reg], QL_W'(1));
                        state_next = S_NOTE;
                    end
                    else
                    begin
                        strobe_next           = 1'b1;
                        res_next.kind         = KIND_NOTICE;
                        res_next.dest_process = src_reg;
                        res_next.last         = 1'b1;
                        qlen_we    = 1'b1;
                        qlen_wdata = '0;
                        walk_next  = 1'b1;
                        proc_next  = '0;
                        state_next = S_ARD;
                    end
                end
                else
                begin
                    proc_next  = PW'(src_reg);
                    first_next = 1'b0;
                    state_next = S_DRD;
                end
            end
            S_NOTE:
            begin
                strobe_next           = 1'b1;
                res_next.kind         = KIND_NOTICE;
                res_next.dest_process = src_reg;
                res_next.has_next     = 1'b1;
                res_next.next_process = q_rdata;
                proc_next  = PW'(q_rdata);
                head_we    = 1'b1;
                head_wdata = wrap_pos(head_reg[sec_reg], QL_W'(1));
                qlen_we    = 1'b1;
                qlen_wdata = len - 1'b1;
                walk_next  = 1'b0;
                first_next = 1'b0;
                state_next = S_ARD;
            end
            S_ARD:
            begin
                state_next = S_AWR;
            end
            S_AWR:
            begin
                // A full list drops the new rank.
                if (len_rdata < CNT_W'(MAX_UPDATES))
                begin
                    pctl.len_we  = 1'b1;
                    pctl.list_we = 1'b1;
                    len_wdata    = len_rdata + 1'b1;
                end
                if (!walk_reg)
                begin
                    state_next = S_DRD;
                end
                else if (proc_reg == PW'(NPROC - 1))
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    proc_next  = proc_reg + 1'b1;
                    state_next = S_ARD;
                end
            end
            S_DRD:
            begin
                state_next = S_DLEN;
            end
            S_DLEN:
            begin
                strobe_next            = 1'b1;
                res_next.kind          = KIND_GRANT;
                res_next.dest_process  = 6'(proc_reg);
                res_next.first_entry   = first_reg;
                res_next.pending_count = 5'(sat_len);
                res_next.last          = (sat_len == '0);
                pctl.len_we = 1'b1;
                len_wdata   = '0;
                n_next      = sat_len;
                i_next      = '0;
                state_next  = (sat_len == '0) ? S_IDLE : S_RANK;
            end
            S_RANK:
            begin
                strobe_next           = 1'b1;
                res_next.kind         = KIND_RANK;
                res_next.dest_process = 6'(proc_reg);
                res_next.pending_rank = list_rdata;
                res_next.last         = (i_reg + 1'b1 == n_reg);
                list_raddr = list_base + LAW'(i_reg) + LAW'(1);
                i_next     = i_reg + 1'b1;
                if (i_reg + 1'b1 == n_reg)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            strobe_reg <= 1'b0;
            walk_reg   <= 1'b0;
            never_reg  <= '1;
            for (int s = 0; s < NCRIT; s++)
            begin
                qlen_reg[s] <= '0;
                head_reg[s] <= '0;
            end
        end
        else
        begin
            state_reg  <= state_next;
            strobe_reg <= strobe_next;
            walk_reg   <= walk_next;
            if (never_clr)
            begin
                never_reg[sec_reg] <= 1'b0;
            end
            if (qlen_we)
            begin
                qlen_reg[sec_reg] <= qlen_wdata;
            end
            if (head_we)
            begin
                head_reg[sec_reg] <= head_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg   <= cmd_next;
        sec_reg   <= sec_next;
        src_reg   <= src_next;
        proc_reg  <= proc_next;
        first_reg <= first_next;
        n_reg     <= n_next;
        i_reg     <= i_next;
        res_reg   <= res_next;
    end

    // Wait queue memory, one circular buffer of NPROC ranks per section.
    always_ff @(posedge clk)
    begin
        if (q_we)
        begin
            qmem[q_addr] <= src_reg;
        end
        q_rdata <= qmem[q_addr];
    end

    cslm_pend #(
        .SLOTS   (SLOTS),
        .ENTRIES (ENTRIES),
        .CNT_W   (CNT_W)
    ) u_pend (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (pctl),
        .len_addr   (slot),
        .len_wdata  (len_wdata),
        .len_rdata  (len_rdata),
        .list_raddr (list_raddr),
        .list_waddr (list_waddr),
        .list_wdata (src_reg),
        .list_rdata (list_rdata),
        .clearing   (clearing)
    );

    assign strobe = strobe_reg;
    assign result = res_reg;

endmodule

/* design/cslm_chk.sv */
// Port level checks of the lock manager and their binding to the top level.
module cslm_chk
    import cslm_pkg::*;
(
    input logic clk,
    input logic rst_n,
    input logic start,
    input logic busy,
    input req_t request,
    input logic strobe,
    input res_t result
);

    a_more_follows: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && !result.last |-> busy)
        else $error("a result beat that is not the last came while the block was free");

    a_no_beat_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> !strobe)
        else $error("a result beat came straight after an item was taken");

    a_error_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && result.kind == KIND_ERROR |-> result.last && result.error_code != ERR_NONE)
        else $error("an error beat was not a lone final beat");

    a_empty_grant_last: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && result.kind == KIND_GRANT && result.pending_count == 5'd0 |-> result.last)
        else $error("a grant with no pending ranks was not the final beat");

    a_rank_follows: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && result.kind == KIND_RANK |-> $past(strobe) &&
            ($past(result.kind) == KIND_GRANT || $past(result.kind) == KIND_RANK))
        else $error("a pending rank beat did not follow a grant or another rank");

endmodule

bind critical_section_lock_manager_core cslm_chk u_chk (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .busy    (busy),
    .request (request),
    .strobe  (strobe),
    .result  (result)
);

/* test/tb_critical_section_lock_manager_core.sv */
// Self-checking testbench for the critical section lock manager core.
module tb_critical_section_lock_manager_core;
    import cslm_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int NPROC       = 64;
    localparam int NCRIT       = 8;
    localparam int MAX_UPDATES = 16;

    // Own copy of the lock manager state, kept beside the block and updated as each
    // input beat is accepted. Each accepted beat pushes the results it must cause.
    class lock_scoreboard;
        logic [5:0] waiters [NCRIT][$];
        bit         unentered [NCRIT];
        logic [5:0] updates [NCRIT][NPROC][$];
        res_t       expected_beats [$];
        int         fail_count;

        function void clear_state();
            for (int s = 0; s < NCRIT; s++)
            begin
                waiters[s].delete();
                unentered[s] = 1'b1;
                for (int p = 0; p < NPROC; p++)
                    updates[s][p].delete();
            end
            expected_beats.delete();
            fail_count = 0;
        endfunction

        function res_t blank_beat(logic [1:0] kind, logic [5:0] dest);
            res_t r;
            r = '0;
            r.kind = kind;
            r.dest_process = dest;
            return r;
        endfunction

        // Grant info to the new holder, then its pending ranks oldest first.
        function void hand_over(int s, logic [5:0] proc, bit first);
            res_t r;
            int n;
            n = updates[s][proc].size();
            r = blank_beat(KIND_GRANT, proc);
            r.first_entry = first;
            r.pending_count = 5'(n);
            r.last = (n == 0);
            expected_beats.push_back(r);
            for (int i = 0; i < n; i++)
            begin
                r = blank_beat(KIND_RANK, proc);
                r.pending_rank = updates[s][proc][i];
                r.last = (i == n - 1);
                expected_beats.push_back(r);
            end
            updates[s][proc].delete();
        endfunction

        function void note_update(int s, int proc, logic [5:0] rank);
            if (updates[s][proc].size() < MAX_UPDATES)
                updates[s][proc].push_back(rank);
        endfunction

        function void note_request(req_t req);
            res_t r;
            int s;
            logic [5:0] src;
            logic [5:0] nxt;
            bit first;
            s = req.section;
            src = req.source_process;
            if (s >= NCRIT || src >= NPROC)
                return;
            case (req.cmd)
                CMD_REQUEST:
                begin
                    if (waiters[s].size() >= NPROC)
                    begin
                        r = blank_beat(KIND_ERROR, src);
                        r.error_code = ERR_QUEUE_FULL;
                        r.last = 1'b1;
                        expected_beats.push_back(r);
                    end
                    else
                    begin
                        waiters[s].push_back(src);
                        if (waiters[s].size() == 1)
                        begin
                            first = unentered[s];
                            unentered[s] = 1'b0;
                            hand_over(s, src, first);
                        end
                    end
                end
                CMD_RELEASE:
                begin
                    if (waiters[s].size() == 0)
                    begin
                        r = blank_beat(KIND_ERROR, src);
                        r.error_code = ERR_EMPTY_REL;
                        r.last = 1'b1;
                        expected_beats.push_back(r);
                    end
                    else if (waiters[s].size() > 1)
                    begin
                        nxt = waiters[s][1];
                        r = blank_beat(KIND_NOTICE, src);
                        r.has_next = 1'b1;
                        r.next_process = nxt;
                        expected_beats.push_back(r);
                        note_update(s, nxt, src);
                        void'(waiters[s].pop_front());
                        hand_over(s, nxt, 1'b0);
                    end
                    else
                    begin
                        // Nobody waits: every process of the section must later see this one.
                        r = blank_beat(KIND_NOTICE, src);
                        r.last = 1'b1;
                        expected_beats.push_back(r);
                        for (int p = 0; p < NPROC; p++)
                            note_update(s, p, src);
                        waiters[s].delete();
                    end
                end
                CMD_FINAL:
                    hand_over(s, src, 1'b0);
                default:
                    ;
            endcase
        endfunction

        function void check_beat(res_t got);
            res_t want;
            if (expected_beats.size() == 0)
            begin
                $error("unexpected result beat %p", got);
                fail_count++;
                return;
            end
            want = expected_beats.pop_front();
            if (got.kind !== want.kind)
            begin
                $error("kind: expected %0d, got %0d", want.kind, got.kind);
                fail_count++;
            end
            if (got.dest_process !== want.dest_process)
            begin
                $error("dest_process: expected %0d, got %0d",
                       want.dest_process, got.dest_process);
                fail_count++;
            end
            if (got.has_next !== want.has_next)
            begin
                $error("has_next: expected %0d, got %0d", want.has_next, got.has_next);
                fail_count++;
            end
            if (got.next_process !== want.next_process)
            begin
                $error("next_process: expected %0d, got %0d",
                       want.next_process, got.next_process);
                fail_count++;
            end
            if (got.first_entry !== want.first_entry)
            begin
                $error("first_entry: expected %0d, got %0d",
                       want.first_entry, got.first_entry);
                fail_count++;
            end
            if (got.pending_count !== want.pending_count)
            begin
                $error("pending_count: expected %0d, got %0d",
                       want.pending_count, got.pending_count);
                fail_count++;
            end
            if (got.pending_rank !== want.pending_rank)
            begin
                $error("pending_rank: expected %0d, got %0d",
                       want.pending_rank, got.pending_rank);
                fail_count++;
            end
            if (got.error_code !== want.error_code)
            begin
                $error("error_code: expected %0d, got %0d",
                       want.error_code, got.error_code);
                fail_count++;
            end
            if (got.last !== want.last)
            begin
                $error("last: expected %0d, got %0d", want.last, got.last);
                fail_count++;
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    logic start;
    logic busy;
    req_t request;
    logic strobe;
    res_t result;

    lock_scoreboard board;
    int burst_left;

    critical_section_lock_manager_core #(
        .NPROC(NPROC),
        .NCRIT(NCRIT),
        .MAX_UPDATES(MAX_UPDATES)
    ) u_top (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .request(request),
        .strobe(strobe),
        .result(result)
    );

    initial clk = 1'b0;
    always #4 clk = ~clk;

    // Inputs are driven on the falling edge, so both the accepting edge and the result
    // beats are seen at the rising edge with settled values. A beat is noted as soon as
    // the block takes it, so the expected results stand ready before the first comes.
    always @(posedge clk)
    begin
        if (rst_n && start && !busy)
            board.note_request(request);
        if (rst_n && strobe)
            board.check_beat(result);
    end

    // Sends one beat and holds start until the block takes it. Between bursts the sender
    // lowers start for a random gap; within a burst start stays high from beat to beat.
    task automatic send_beat(logic [1:0] cmd, int sec, int src);
        @(negedge clk);
        if (burst_left == 0)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 12)) @(negedge clk);
            burst_left = $urandom_range(1, 10);
        end
        start <= 1'b1;
        request <= '{cmd: cmd, section: 3'(sec), source_process: 6'(src)};
        @(posedge clk);
        while (busy)
            @(posedge clk);
        burst_left--;
    endtask

    // Lets the block finish: waits for every expected beat and some spare cycles,
    // long enough for a release without waiters to sweep the whole section.
    task automatic drain_results();
        @(negedge clk);
        start <= 1'b0;
        while (board.expected_beats.size() != 0)
            @(negedge clk);
        repeat (2 * NPROC + 20) @(negedge clk);
    endtask

    // Random traffic on all sections: mostly orderly request and release cycles,
    // with errors, final updates and stray commands mixed in.
    task automatic random_traffic(int count);
        int sec;
        int pick;
        for (int i = 0; i < count; i++)
        begin
            sec = $urandom_range(0, 7);
            pick = $urandom_range(0, 99);
            if (pick < 40)
                send_beat(CMD_REQUEST, sec, $urandom_range(0, 63));
            else if (pick < 70 && board.waiters[sec].size() != 0)
                send_beat(CMD_RELEASE, sec, board.waiters[sec][0]);
            else if (pick < 78)
                send_beat(CMD_RELEASE, sec, $urandom_range(0, 63));
            else if (pick < 92)
                send_beat(CMD_FINAL, sec, $urandom_range(0, 63));
            else
                send_beat(2'd3, sec, $urandom_range(0, 63));
        end
    endtask

    initial
    begin
        board = new();
        board.clear_state();
        rst_n = 1'b0;
        start = 1'b0;
        request = '0;
        burst_left = 0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed part: first entry, a waiter taking over, a release with nobody
        // waiting, release on an empty queue, the final update and a stray command.
        send_beat(CMD_REQUEST, 0, 0);
        send_beat(CMD_REQUEST, 0, 63);
        send_beat(CMD_RELEASE, 0, 0);
        send_beat(CMD_RELEASE, 0, 63);
        send_beat(CMD_RELEASE, 0, 5);
        send_beat(CMD_REQUEST, 7, 42);
        send_beat(CMD_REQUEST, 0, 21);
        send_beat(CMD_FINAL, 0, 63);
        send_beat(CMD_FINAL, 0, 0);
        send_beat(2'd3, 7, 63);
        send_beat(CMD_RELEASE, 7, 42);

        // Saturate the pending lists of section 3 with repeated lone entries.
        for (int i = 0; i < 18; i++)
        begin
            send_beat(CMD_REQUEST, 3, i);
            send_beat(CMD_RELEASE, 3, i);
        end
        send_beat(CMD_FINAL, 3, 63);

        // The sender holds off here until every expected beat has come back.
        drain_results();

        // Fill section 5 to its full depth, then one request too many.
        for (int p = 0; p < NPROC; p++)
            send_beat(CMD_REQUEST, 5, p);
        send_beat(CMD_REQUEST, 5, 9);
        for (int p = 0; p < 20; p++)
            send_beat(CMD_RELEASE, 5, p);

        random_traffic(100);
        drain_results();

        if (board.fail_count == 0 && board.expected_beats.size() == 0)
            $display("** critical_section_lock_manager_core: PASSED **");
        else
            $display("** critical_section_lock_manager_core: FAILED **");
        $finish;
    end

    initial
    begin
        #20ms;
        $display("** critical_section_lock_manager_core: FAILED **");
        $finish;
    end

endmodule
